/* hdl/jlad_pkg.sv */
// Shared types, character codes and register indexes of the joystick line axis decoder.
package jlad_pkg;

   localparam int OFFSET_W = 11;
   localparam int CSR_DATA_W = 10;
   localparam int CSR_INDEX_W = 3;
   localparam int CENTER_W = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_X_CENTER    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_CENTER    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_BAND = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_X    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_Y    = 3'd4;

   localparam logic [CENTER_W-1:0] RESET_CENTER      = 10'd512;
   localparam logic [CENTER_W-1:0] RESET_CENTER_BAND = 10'd3;

   localparam logic [7:0] CHAR_NL      = 8'd10;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_TAB     = 8'd9;
   localparam logic [7:0] CHAR_CR      = 8'd13;
   localparam logic [7:0] CHAR_PLUS    = 8'd43;
   localparam logic [7:0] CHAR_COMMA   = 8'd44;
   localparam logic [7:0] CHAR_MINUS   = 8'd45;
   localparam logic [7:0] CHAR_ZERO    = 8'd48;
   localparam logic [7:0] CHAR_NINE    = 8'd57;
   localparam logic [7:0] CHAR_EQUAL   = 8'd61;
   localparam logic [7:0] CHAR_UPPER_A = 8'd65;
   localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
   localparam logic [7:0] CHAR_LOWER_X = 8'd120;
   localparam logic [7:0] CHAR_LOWER_Y = 8'd121;
   localparam logic [7:0] CASE_OFFSET  = 8'd32;

   typedef enum logic [3:0] {
      PL_START = 4'd0,
      PL_SIGN1 = 4'd1,
      PL_DIG1  = 4'd2,
      PL_COMMA = 4'd3,
      PL_SIGN2 = 4'd4,
      PL_DIG2  = 4'd5,
      PL_DONE  = 4'd6,
      PL_DEAD  = 4'd7
   } plain_phase_type;

   typedef enum logic [3:0] {
      LB_SEEK  = 4'd0,
      LB_X     = 4'd1,
      LB_EQ1   = 4'd2,
      LB_DIGX  = 4'd3,
      LB_WSX   = 4'd4,
      LB_COMMA = 4'd5,
      LB_Y     = 4'd6,
      LB_EQ2   = 4'd7,
      LB_DIGY  = 4'd8,
      LB_DONE  = 4'd9
   } label_phase_type;

   // Per-cycle command to both parsers.
   typedef struct packed {
      logic advance;   // a non-newline character is consumed
      logic clear;     // a newline is consumed; the line is judged and reset
   } step_ctl_type;

   typedef struct packed {
      logic pair_ok;
      logic first_neg;
      logic second_neg;
   } plain_status_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR) && (c != CHAR_NL));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ? c + CASE_OFFSET : c;
   endfunction

endpackage

/* hdl/jlad_digit_acc.sv */
// Saturating decimal digit accumulator: value times ten plus one digit.
module jlad_digit_acc #(
   parameter int VALUE_W   = 12,
   parameter int DIGIT_CAP = 4095
) (
   input  logic [VALUE_W-1:0] base,
   input  logic [7:0]         in_byte,
   output logic [VALUE_W-1:0] result
);

   localparam int SUM_W = VALUE_W + 4;

   logic [SUM_W-1:0] base_ext;
   logic [SUM_W-1:0] digit_ext;
   logic [SUM_W-1:0] sum;

   always_comb begin
      base_ext  = SUM_W'(base);
      digit_ext = SUM_W'(in_byte - jlad_pkg::CHAR_ZERO);
      sum       = (base_ext << 3) + (base_ext << 1) + digit_ext;
      result    = (sum > SUM_W'(DIGIT_CAP)) ? VALUE_W'(DIGIT_CAP) : sum[VALUE_W-1:0];
   end

endmodule

/* hdl/jlad_plain_parser.sv */
// Anchored parser for the plain signed comma pair form of a line.
module jlad_plain_parser #(
   parameter int VALUE_W   = 12,
   parameter int DIGIT_CAP = 4095
) (
   input  logic                       clock,
   input  logic                       reset,
   input  jlad_pkg::step_ctl_type     ctl,
   input  logic [7:0]                 in_byte,
   output jlad_pkg::plain_status_type status,
   output logic [VALUE_W-1:0]         first_mag,
   output logic [VALUE_W-1:0]         second_mag
);

   jlad_pkg::plain_phase_type phase_ff, phase_in;
   logic               neg_ff, neg_in;
   logic               first_neg_ff, first_neg_in;
   logic [VALUE_W-1:0] first_ff, first_in;
   logic [VALUE_W-1:0] second_ff, second_in;
   logic [VALUE_W-1:0] acc_base, acc_out;
   logic               ws, digit, sign, minus;

   assign ws    = jlad_pkg::is_ws(in_byte);
   assign digit = jlad_pkg::is_digit(in_byte);
   assign minus = (in_byte == jlad_pkg::CHAR_MINUS);
   assign sign  = minus || (in_byte == jlad_pkg::CHAR_PLUS);

   // Only one of the two values grows at a time, so one accumulator serves both.
   always_comb begin
      if (phase_ff == jlad_pkg::PL_DIG1) begin
         acc_base = first_ff;
      end else if (phase_ff == jlad_pkg::PL_DIG2) begin
         acc_base = second_ff;
      end else begin
         acc_base = '0;
      end
   end

   jlad_digit_acc #(.VALUE_W(VALUE_W), .DIGIT_CAP(DIGIT_CAP)) u_acc (
      .base    (acc_base),
      .in_byte (in_byte),
      .result  (acc_out)
   );

   always_comb begin
      phase_in = phase_ff;
      if (ctl.clear) begin
         phase_in = jlad_pkg::PL_START;
      end else if (ctl.advance) begin
         unique case (phase_ff)
            jlad_pkg::PL_START: begin
               if (ws) phase_in = phase_ff;
               else if (sign) phase_in = jlad_pkg::PL_SIGN1;
               else if (digit) phase_in = jlad_pkg::PL_DIG1;
               else phase_in = jlad_pkg::PL_DEAD;
            end
            jlad_pkg::PL_COMMA: begin
               if (ws) phase_in = phase_ff;
               else if (sign) phase_in = jlad_pkg::PL_SIGN2;
               else if (digit) phase_in = jlad_pkg::PL_DIG2;
               else phase_in = jlad_pkg::PL_DEAD;
            end
            jlad_pkg::PL_SIGN1: phase_in = digit ? jlad_pkg::PL_DIG1 : jlad_pkg::PL_DEAD;
            jlad_pkg::PL_SIGN2: phase_in = digit ? jlad_pkg::PL_DIG2 : jlad_pkg::PL_DEAD;
            jlad_pkg::PL_DIG1: begin
               if (digit) phase_in = phase_ff;
               else if (in_byte == jlad_pkg::CHAR_COMMA) phase_in = jlad_pkg::PL_COMMA;
               else phase_in = jlad_pkg::PL_DEAD;
            end
            jlad_pkg::PL_DIG2: phase_in = digit ? phase_ff : jlad_pkg::PL_DONE;
            jlad_pkg::PL_DONE, jlad_pkg::PL_DEAD: phase_in = phase_ff;
            default: phase_in = jlad_pkg::PL_DEAD;
         endcase
      end
   end

   always_comb begin
      neg_in       = neg_ff;
      first_neg_in = first_neg_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      if (ctl.clear) begin
         neg_in       = 1'b0;
         first_neg_in = 1'b0;
         first_in     = '0;
         second_in    = '0;
      end else if (ctl.advance) begin
         case (phase_ff)
            jlad_pkg::PL_START: begin
               if (!ws) neg_in = minus;
               if (digit) begin
                  first_in     = acc_out;
                  first_neg_in = 1'b0;
               end
            end
            jlad_pkg::PL_COMMA: begin
               if (!ws) neg_in = minus;
               if (digit) second_in = acc_out;
            end
            jlad_pkg::PL_SIGN1, jlad_pkg::PL_DIG1: begin
               if (digit) begin
                  first_in     = acc_out;
                  first_neg_in = neg_ff;
               end
            end
            jlad_pkg::PL_SIGN2, jlad_pkg::PL_DIG2: begin
               if (digit) second_in = acc_out;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= jlad_pkg::PL_START;
         neg_ff       <= 1'b0;
         first_neg_ff <= 1'b0;
         first_ff     <= '0;
         second_ff    <= '0;
      end else begin
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         first_neg_ff <= first_neg_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
      end
   end

   always_comb begin
      status.pair_ok    = (phase_ff == jlad_pkg::PL_DIG2) || (phase_ff == jlad_pkg::PL_DONE);
      status.first_neg  = first_neg_ff;
      status.second_neg = neg_ff;
      first_mag         = first_ff;
      second_mag        = second_ff;
   end

endmodule

/* hdl/jlad_label_parser.sv */
// Case-insensitive leftmost search for the labeled x=..,y=.. form of a line.
module jlad_label_parser #(
   parameter int VALUE_W   = 12,
   parameter int DIGIT_CAP = 4095
) (
   input  logic                   clock,
   input  logic                   reset,
   input  jlad_pkg::step_ctl_type ctl,
   input  logic [7:0]             in_byte,
   output logic                   found,
   output logic [VALUE_W-1:0]     first_val,
   output logic [VALUE_W-1:0]     second_val
);

   jlad_pkg::label_phase_type phase_ff, phase_in;
   logic               found_ff, found_in;
   logic [VALUE_W-1:0] first_ff, first_in;
   logic [VALUE_W-1:0] second_ff, second_in;
   logic [VALUE_W-1:0] acc_base, acc_out;
   logic [7:0]         low;
   logic               ws, digit, ok;

   assign low   = jlad_pkg::to_lower(in_byte);
   assign ws    = jlad_pkg::is_ws(in_byte);
   assign digit = jlad_pkg::is_digit(in_byte);

   always_comb begin
      if (phase_ff == jlad_pkg::LB_DIGX) begin
         acc_base = first_ff;
      end else if (phase_ff == jlad_pkg::LB_DIGY) begin
         acc_base = second_ff;
      end else begin
         acc_base = '0;
      end
   end

   jlad_digit_acc #(.VALUE_W(VALUE_W), .DIGIT_CAP(DIGIT_CAP)) u_acc (
      .base    (acc_base),
      .in_byte (in_byte),
      .result  (acc_out)
   );

   // A character that does not fit the pattern restarts the search; an x restarts it
   // one step in.
   always_comb begin
      unique case (phase_ff)
         jlad_pkg::LB_SEEK:  ok = 1'b0;
         jlad_pkg::LB_X:     ok = (low == jlad_pkg::CHAR_EQUAL) || ws;
         jlad_pkg::LB_EQ1:   ok = digit || ws;
         jlad_pkg::LB_DIGX:  ok = digit || (low == jlad_pkg::CHAR_COMMA) || ws;
         jlad_pkg::LB_WSX:   ok = (low == jlad_pkg::CHAR_COMMA) || ws;
         jlad_pkg::LB_COMMA: ok = (low == jlad_pkg::CHAR_LOWER_Y) || ws;
         jlad_pkg::LB_Y:     ok = (low == jlad_pkg::CHAR_EQUAL) || ws;
         jlad_pkg::LB_EQ2:   ok = digit || ws;
         jlad_pkg::LB_DIGY, jlad_pkg::LB_DONE: ok = 1'b1;
         default:            ok = 1'b0;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      if (ctl.clear) begin
         phase_in = jlad_pkg::LB_SEEK;
      end else if (ctl.advance) begin
         if (!ok) begin
            phase_in = (low == jlad_pkg::CHAR_LOWER_X) ? jlad_pkg::LB_X : jlad_pkg::LB_SEEK;
         end else begin
            unique case (phase_ff)
               jlad_pkg::LB_X:
                  if (low == jlad_pkg::CHAR_EQUAL) phase_in = jlad_pkg::LB_EQ1;
               jlad_pkg::LB_EQ1:
                  if (digit) phase_in = jlad_pkg::LB_DIGX;
               jlad_pkg::LB_DIGX: begin
                  if (digit) phase_in = phase_ff;
                  else if (low == jlad_pkg::CHAR_COMMA) phase_in = jlad_pkg::LB_COMMA;
                  else phase_in = jlad_pkg::LB_WSX;
               end
               jlad_pkg::LB_WSX:
                  if (low == jlad_pkg::CHAR_COMMA) phase_in = jlad_pkg::LB_COMMA;
               jlad_pkg::LB_COMMA:
                  if (low == jlad_pkg::CHAR_LOWER_Y) phase_in = jlad_pkg::LB_Y;
               jlad_pkg::LB_Y:
                  if (low == jlad_pkg::CHAR_EQUAL) phase_in = jlad_pkg::LB_EQ2;
               jlad_pkg::LB_EQ2:
                  if (digit) phase_in = jlad_pkg::LB_DIGY;
               jlad_pkg::LB_DIGY:
                  if (!digit) phase_in = jlad_pkg::LB_DONE;
               jlad_pkg::LB_SEEK, jlad_pkg::LB_DONE: phase_in = phase_ff;
               default: phase_in = jlad_pkg::LB_SEEK;
            endcase
         end
      end
   end

   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      found_in  = found_ff;
      if (ctl.clear) begin
         first_in  = '0;
         second_in = '0;
         found_in  = 1'b0;
      end else if (ctl.advance) begin
         if (!ok) begin
            first_in  = '0;
            second_in = '0;
         end else if (digit) begin
            case (phase_ff)
               jlad_pkg::LB_EQ1, jlad_pkg::LB_DIGX: first_in = acc_out;
               jlad_pkg::LB_EQ2: begin
                  second_in = acc_out;
                  found_in  = 1'b1;
               end
               jlad_pkg::LB_DIGY: second_in = acc_out;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= jlad_pkg::LB_SEEK;
         found_ff  <= 1'b0;
         first_ff  <= '0;
         second_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         found_ff  <= found_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   assign found      = found_ff;
   assign first_val  = first_ff;
   assign second_val = second_ff;

endmodule

/* hdl/jlad_axis_norm.sv */
// Dead zone, clamp, centering and optional negation of one axis value.
module jlad_axis_norm #(
   parameter int VALUE_W = 12,
   parameter int ADC_MAX = 1023
) (
   input  logic [VALUE_W-1:0]                 mag,
   input  logic                               neg,
   input  logic [jlad_pkg::CENTER_W-1:0]      center,
   input  logic [jlad_pkg::CENTER_W-1:0]      center_band,
   input  logic                               invert,
   output logic signed [jlad_pkg::OFFSET_W-1:0] offset
);

   localparam int ADC_W  = $clog2(ADC_MAX + 1);
   localparam int WIDE_W = (VALUE_W > ADC_W) ? VALUE_W : ADC_W;
   localparam int BASE_W = (WIDE_W > jlad_pkg::CENTER_W) ? WIDE_W : jlad_pkg::CENTER_W;
   localparam int NW     = BASE_W + 2;

   logic signed [NW-1:0] mag_s, value, ctr, dz, diff, span, held, clamped, rel;

   always_comb begin
      mag_s   = $signed(NW'(mag));
      value   = neg ? -mag_s : mag_s;
      ctr     = $signed(NW'(center));
      dz      = $signed(NW'(center_band));
      diff    = value - ctr;
      span    = (diff < 0) ? -diff : diff;
      held    = (span <= dz) ? ctr : value;
      if (held < 0) begin
         clamped = '0;
      end else if (held > $signed(NW'(ADC_MAX))) begin
         clamped = $signed(NW'(ADC_MAX));
      end else begin
         clamped = held;
      end
      rel     = clamped - ctr;
      if (invert) rel = -rel;
      offset  = rel[jlad_pkg::OFFSET_W-1:0];
   end

endmodule

/* hdl/joystick_line_axis_decoder.sv */
// Top level of the joystick line axis decoder: handshakes, control registers, result register.
//
// The block takes one received character per cycle on the req_ channel while req_stall
// is low and emits one result on the rsp_ channel for each newline that closes a line
// that parses, either as a plain signed pair "x,y" anchored at line start (line_format 0)
// or, failing that, as a labeled "x=..,y=.." pair found anywhere in the line (line_format 1).
// Lines that parse to nothing produce no transfer. A character is registered on acceptance
// and then consumed by both parsers, a newline only once no stalled result is pending; a
// newline's result is loaded into the output register as the newline is consumed. Sustained
// rate is one character per cycle while req_stall stays low. req_stall rises only while a
// newline sits in the input register and the output register holds a result, so input is
// held back whenever a newline meets a pending result, even one being taken. Digit runs
// saturate at DIGIT_CAP, and each axis is then dead-zoned, clamped to 0..ADC_MAX and
// referred to its center. Configuration registers are written through csr_ with no wait
// and must only be changed while no line is in progress.
module joystick_line_axis_decoder #(
   parameter int ADC_MAX   = 1023,
   parameter int DIGIT_CAP = 4095
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [7:0]                             req_in_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [jlad_pkg::OFFSET_W-1:0]   rsp_x_offset,
   output logic signed [jlad_pkg::OFFSET_W-1:0]   rsp_y_offset,
   output logic                                   rsp_line_format,
   input  logic                                   csr_write_en,
   input  logic [jlad_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [jlad_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int VALUE_W = $clog2(DIGIT_CAP + 1);

   // Configuration registers.
   logic [jlad_pkg::CENTER_W-1:0] x_center_ff, y_center_ff, center_band_ff;
   logic                          invert_x_ff, invert_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_center_ff    <= jlad_pkg::RESET_CENTER;
         y_center_ff    <= jlad_pkg::RESET_CENTER;
         center_band_ff <= jlad_pkg::RESET_CENTER_BAND;
         invert_x_ff    <= 1'b0;
         invert_y_ff    <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            jlad_pkg::CSR_X_CENTER:    x_center_ff    <= csr_wdata;
            jlad_pkg::CSR_Y_CENTER:    y_center_ff    <= csr_wdata;
            jlad_pkg::CSR_CENTER_BAND: center_band_ff <= csr_wdata;
            jlad_pkg::CSR_INVERT_X:    invert_x_ff    <= csr_wdata[0];
            jlad_pkg::CSR_INVERT_Y:    invert_y_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Input register. A held character always moves on in the next cycle unless it
   // is a newline blocked by a result that has not been taken yet.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_is_nl, req_take, fire, load_rsp;
   jlad_pkg::step_ctl_type ctl;

   assign in_is_nl  = (in_byte_ff == jlad_pkg::CHAR_NL);
   assign req_stall = in_valid_ff && in_is_nl && rsp_valid;
   assign req_take  = req_valid && !req_stall;
   assign fire      = in_valid_ff && !(in_is_nl && rsp_valid && rsp_stall);

   always_comb begin
      ctl.advance = fire && !in_is_nl;
      ctl.clear   = fire && in_is_nl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_byte_ff <= req_in_byte;
   end

   // The two parsers watch the same character stream side by side.
   jlad_pkg::plain_status_type plain_status;
   logic [VALUE_W-1:0] plain_first, plain_second;
   logic               label_found;
   logic [VALUE_W-1:0] label_first, label_second;

   jlad_plain_parser #(.VALUE_W(VALUE_W), .DIGIT_CAP(DIGIT_CAP)) u_plain (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .in_byte    (in_byte_ff),
      .status     (plain_status),
      .first_mag  (plain_first),
      .second_mag (plain_second)
   );

   jlad_label_parser #(.VALUE_W(VALUE_W), .DIGIT_CAP(DIGIT_CAP)) u_label (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .in_byte    (in_byte_ff),
      .found      (label_found),
      .first_val  (label_first),
      .second_val (label_second)
   );

   // The plain form wins whenever it completed; the labeled form is the fallback.
   logic [VALUE_W-1:0] sel_x_mag, sel_y_mag;
   logic               sel_x_neg, sel_y_neg;
   logic signed [jlad_pkg::OFFSET_W-1:0] x_norm, y_norm;

   always_comb begin
      if (plain_status.pair_ok) begin
         sel_x_mag = plain_first;
         sel_x_neg = plain_status.first_neg;
         sel_y_mag = plain_second;
         sel_y_neg = plain_status.second_neg;
      end else begin
         sel_x_mag = label_first;
         sel_x_neg = 1'b0;
         sel_y_mag = label_second;
         sel_y_neg = 1'b0;
      end
   end

   jlad_axis_norm #(.VALUE_W(VALUE_W), .ADC_MAX(ADC_MAX)) u_norm_x (
      .mag         (sel_x_mag),
      .neg         (sel_x_neg),
      .center      (x_center_ff),
      .center_band (center_band_ff),
      .invert      (invert_x_ff),
      .offset      (x_norm)
   );

   jlad_axis_norm #(.VALUE_W(VALUE_W), .ADC_MAX(ADC_MAX)) u_norm_y (
      .mag         (sel_y_mag),
      .neg         (sel_y_neg),
      .center      (y_center_ff),
      .center_band (center_band_ff),
      .invert      (invert_y_ff),
      .offset      (y_norm)
   );

   // Output register. It is loaded by a newline that closes a parsed line and
   // emptied by a transfer on rsp_.
   logic rsp_valid_ff;
   logic signed [jlad_pkg::OFFSET_W-1:0] x_offset_ff, y_offset_ff;
   logic line_format_ff;

   assign load_rsp = ctl.clear && (plain_status.pair_ok || label_found);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         x_offset_ff    <= x_norm;
         y_offset_ff    <= y_norm;
         line_format_ff <= !plain_status.pair_ok;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_x_offset    = x_offset_ff;
   assign rsp_y_offset    = y_offset_ff;
   assign rsp_line_format = line_format_ff;

endmodule

/* hdl/jlad_checker.sv */
// Port-level assertions for the joystick line axis decoder and their binding.
module jlad_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [jlad_pkg::OFFSET_W-1:0] rsp_x_offset,
   input logic signed [jlad_pkg::OFFSET_W-1:0] rsp_y_offset,
   input logic                                 rsp_line_format
);

   // A result waiting on backpressure keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_x_offset)
         && $stable(rsp_y_offset) && $stable(rsp_line_format))
      else $error("result changed while stalled");

   // Input is held back only while an earlier result is still pending.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output register");

   // A result leaves only through a transfer.
   a_rsp_leave: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(!rsp_stall))
      else $error("result dropped without transfer");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

endmodule

bind joystick_line_axis_decoder jlad_checker u_jlad_checker (.*);
